// ----- rtl/lc3_pkg.sv -----
// ----------------------------------------------------------------------------
// lc3_pkg: shared types, constants and helpers for the educational CPU core
// Memory size, opcodes, trap vectors and condition code helpers.
// ----------------------------------------------------------------------------
package lc3_pkg;

    localparam int MEM_DEPTH = 65536;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam logic [15:0] START_PC_RST = 16'h3000;
    localparam logic [15:0] KBSR_ADDR    = 16'hFE00;
    localparam logic [15:0] KBDR_ADDR    = 16'hFE02;
    localparam logic [15:0] KBSR_READY   = 16'h8000;

    localparam logic [7:0] VEC_GETC = 8'h20;
    localparam logic [7:0] VEC_IN   = 8'h23;
    localparam logic [7:0] VEC_HALT = 8'h25;

    localparam logic [2:0] CC_P = 3'd1;
    localparam logic [2:0] CC_Z = 3'd2;
    localparam logic [2:0] CC_N = 3'd4;

    typedef enum logic [3:0] {
        OP_BR   = 4'h0,
        OP_ADD  = 4'h1,
        OP_LD   = 4'h2,
        OP_ST   = 4'h3,
        OP_JSR  = 4'h4,
        OP_AND  = 4'h5,
        OP_LDR  = 4'h6,
        OP_STR  = 4'h7,
        OP_RTI  = 4'h8,
        OP_NOT  = 4'h9,
        OP_LDI  = 4'hA,
        OP_STI  = 4'hB,
        OP_JMP  = 4'hC,
        OP_RES  = 4'hD,
        OP_LEA  = 4'hE,
        OP_TRAP = 4'hF
    } t_opcode;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_AND,
        ALU_NOT
    } t_alu_op;

    function automatic logic [2:0] cc_of(input logic [15:0] v);
        logic [2:0] c;
        if (v == 16'h0000) begin
            c = CC_Z;
        end else if (v[15]) begin
            c = CC_N;
        end else begin
            c = CC_P;
        end
        return c;
    endfunction

    function automatic logic [MEM_AW-1:0] mem_idx(input logic [15:0] a);
        logic [16:0] w;
        w = 17'({1'b0, a} % MEM_DEPTH);
        return w[MEM_AW-1:0];
    endfunction

endpackage

// ----- rtl/lc3_mem.sv -----
// ----------------------------------------------------------------------------
// lc3_mem: single-port word memory
// One read or write per cycle; read data registered.
// ----------------------------------------------------------------------------
module lc3_mem (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [lc3_pkg::MEM_AW-1:0] i_addr,
    input  logic [15:0]                i_wdata,
    output logic [15:0]                o_rdata
);
    import lc3_pkg::*;

    logic [15:0] r_mem [MEM_DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/lc3_regs.sv -----
// ----------------------------------------------------------------------------
// lc3_regs: general register file
// Eight words, one registered read port and one write port.
// ----------------------------------------------------------------------------
module lc3_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [2:0]  i_raddr,
    input  logic        i_we,
    input  logic [2:0]  i_waddr,
    input  logic [15:0] i_wdata,
    output logic [15:0] o_rdata
);
    import lc3_pkg::*;

    logic [15:0] r_regs [8];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) begin
                r_regs[k] <= '0;
            end
            r_rdata <= '0;
        end else begin
            if (i_we) begin
                r_regs[i_waddr] <= i_wdata;
            end
            r_rdata <= r_regs[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/lc3_alu.sv -----
// ----------------------------------------------------------------------------
// lc3_alu: shared arithmetic unit
// Add, and, not; used for data ops, address and branch target sums.
// ----------------------------------------------------------------------------
module lc3_alu (
    input  lc3_pkg::t_alu_op i_op,
    input  logic [15:0]      i_a,
    input  logic [15:0]      i_b,
    output logic [15:0]      o_y
);
    import lc3_pkg::*;

    always_comb begin
        unique case (i_op)
            ALU_AND: o_y = i_a & i_b;
            ALU_NOT: o_y = ~i_a;
            default: o_y = i_a + i_b;
        endcase
    end

endmodule

// ----- rtl/educational_cpu_instruction_step.sv -----
// ----------------------------------------------------------------------------
// educational_cpu_instruction_step: 16-bit educational processor core
// Load items write memory; step items fetch and execute one instruction.
// ----------------------------------------------------------------------------
// A load item passes through the load and done states. A step item passes
// through decode, operand, execute and done; LD, LDR and STI add a read and a
// data state, LDI adds them twice, and a key trap that takes a character adds
// a state that writes the character to R0. A read of the keyboard status word
// also passes through a state that writes the keyboard data register when a
// key is ready. A step item on a stopped core goes straight to the done state.
// The single memory port (fetch, data reads, writes) and the single register
// read port set this sequence. The input is stalled until the result has been
// placed in the output register, so a stalled output also holds off the input.
// The start_pc register is accepted at any time; the program counter takes
// 0x3000 at reset.
module educational_cpu_instruction_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [15:0] i_load_address,
    input  logic [15:0] i_load_data,
    input  logic        i_key_ready,
    input  logic [7:0]  i_key_char,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_next_pc,
    output logic [2:0]  o_cond_code,
    output logic        o_trap_taken,
    output logic [7:0]  o_trap_vector,
    output logic [15:0] o_reg0_value,
    output logic        o_key_used,
    output logic        o_halted,
    output logic        o_fault
);
    import lc3_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_DECODE, S_OPB, S_EXEC, S_RD, S_KBDR, S_DATA, S_WR0, S_DONE
    } t_state;

    t_state      r_state;
    logic [15:0] r_start_pc;
    logic [15:0] r_pc, r_r0, r_ins, r_a, r_b, r_addr, r_val;
    logic [2:0]  r_cc;
    logic        r_stopped, r_fault, r_ind, r_from_mem;
    logic        r_op, r_kready;
    logic [15:0] r_laddr, r_ldata;
    logic [7:0]  r_kchar, r_vec;
    logic        r_trap, r_kused;

    logic        r_out_valid;
    logic [15:0] r_o_pc, r_o_r0;
    logic [2:0]  r_o_cc;
    logic        r_o_trap, r_o_kused, r_o_halted, r_o_fault;
    logic [7:0]  r_o_vec;

    logic              m_we;
    logic [MEM_AW-1:0] m_addr;
    logic [15:0]       m_wdata, m_rdata;
    logic [2:0]        rf_raddr, rf_waddr;
    logic              rf_we;
    logic [15:0]       rf_wdata, rf_rdata;
    t_alu_op           alu_op;
    logic [15:0]       alu_a, alu_b, alu_y;
    t_opcode           opc;
    logic [15:0]       data_val;
    logic              key_trap;

    assign opc      = t_opcode'(r_ins[15:12]);
    assign data_val = r_from_mem ? m_rdata : r_val;
    assign key_trap = (r_ins[7:0] == VEC_GETC) || (r_ins[7:0] == VEC_IN);

    lc3_mem u_mem (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_addr (m_addr),
        .i_wdata(m_wdata),
        .o_rdata(m_rdata)
    );

    lc3_regs u_regs (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_raddr(rf_raddr),
        .i_we   (rf_we),
        .i_waddr(rf_waddr),
        .i_wdata(rf_wdata),
        .o_rdata(rf_rdata)
    );

    lc3_alu u_alu (
        .i_op(alu_op),
        .i_a (alu_a),
        .i_b (alu_b),
        .o_y (alu_y)
    );

    // shared unit operand selection
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = r_pc;
        alu_b  = {{7{r_ins[8]}}, r_ins[8:0]};
        case (opc)
            OP_ADD, OP_AND: begin
                alu_op = (opc == OP_AND) ? ALU_AND : ALU_ADD;
                alu_a  = r_a;
                alu_b  = r_ins[5] ? {{11{r_ins[4]}}, r_ins[4:0]} : rf_rdata;
            end
            OP_NOT: begin
                alu_op = ALU_NOT;
                alu_a  = r_a;
            end
            OP_LDR, OP_STR: begin
                alu_a = r_a;
                alu_b = {{10{r_ins[5]}}, r_ins[5:0]};
            end
            OP_JSR: alu_b = {{5{r_ins[10]}}, r_ins[10:0]};
            default: ;
        endcase
    end

    // memory port and register port control
    always_comb begin
        m_we     = 1'b0;
        m_addr   = mem_idx(r_pc);
        m_wdata  = r_b;
        rf_raddr = r_ins[8:6];
        rf_we    = 1'b0;
        rf_waddr = r_ins[11:9];
        rf_wdata = alu_y;
        unique case (r_state)
            S_LOAD: begin
                m_we    = 1'b1;
                m_addr  = mem_idx(r_laddr);
                m_wdata = r_ldata;
            end
            S_DECODE: rf_raddr = m_rdata[8:6];
            S_OPB: begin
                rf_raddr = (opc == OP_ST || opc == OP_STR || opc == OP_STI)
                         ? r_ins[11:9] : r_ins[2:0];
            end
            S_EXEC: begin
                unique case (opc)
                    OP_ADD, OP_AND, OP_NOT, OP_LEA: rf_we = 1'b1;
                    OP_JSR: begin
                        rf_we    = 1'b1;
                        rf_waddr = 3'd7;
                        rf_wdata = r_pc;
                    end
                    OP_ST, OP_STR: begin
                        m_we    = 1'b1;
                        m_addr  = mem_idx(alu_y);
                        m_wdata = rf_rdata;
                    end
                    OP_TRAP: begin
                        rf_we    = !(key_trap && !r_kready);
                        rf_waddr = 3'd7;
                        rf_wdata = r_pc;
                    end
                    default: ;
                endcase
            end
            S_RD: begin
                m_addr = mem_idx(r_addr);
                if (r_addr == KBSR_ADDR) begin
                    m_we    = 1'b1;
                    m_wdata = r_kready ? KBSR_READY : 16'h0000;
                end
            end
            S_KBDR: begin
                m_we    = 1'b1;
                m_addr  = mem_idx(KBDR_ADDR);
                m_wdata = {8'h00, r_kchar};
            end
            S_DATA: begin
                if (r_ind && opc == OP_STI) begin
                    m_we   = 1'b1;
                    m_addr = mem_idx(data_val);
                end else if (!r_ind) begin
                    rf_we    = 1'b1;
                    rf_wdata = data_val;
                end
            end
            S_WR0: begin
                rf_we    = 1'b1;
                rf_waddr = 3'd0;
                rf_wdata = {8'h00, r_kchar};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start_pc  <= START_PC_RST;
            r_pc        <= START_PC_RST;
            r_r0        <= '0;
            r_cc        <= CC_Z;
            r_stopped   <= 1'b0;
            r_fault     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_start_pc <= i_cfg_data;
            end
            if (rf_we) begin
                if (rf_waddr == 3'd0) begin
                    r_r0 <= rf_wdata;
                end
                if (r_state != S_EXEC || opc != OP_JSR && opc != OP_TRAP) begin
                    r_cc <= cc_of(rf_wdata);
                end
            end
            // the done state loads the output register itself
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_operation;
                        r_laddr <= i_load_address;
                        r_ldata <= i_load_data;
                        r_kready <= i_key_ready;
                        r_kchar <= i_key_char;
                        r_trap  <= 1'b0;
                        r_vec   <= '0;
                        r_kused <= 1'b0;
                        if (!i_operation) begin
                            r_state <= S_LOAD;
                        end else if (r_stopped) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_DECODE;
                        end
                    end
                end
                S_LOAD: r_state <= S_DONE;
                S_DECODE: begin
                    r_ins   <= m_rdata;
                    r_pc    <= r_pc + 16'd1;
                    r_state <= S_OPB;
                end
                S_OPB: begin
                    r_a     <= rf_rdata;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_b     <= rf_rdata;
                    r_addr  <= alu_y;
                    r_ind   <= (opc == OP_LDI) || (opc == OP_STI);
                    if (opc == OP_LD || opc == OP_LDI || opc == OP_LDR || opc == OP_STI) begin
                        r_state <= S_RD;
                    end else if (opc == OP_TRAP && key_trap && r_kready) begin
                        r_state <= S_WR0;
                    end else begin
                        r_state <= S_DONE;
                    end
                    unique case (opc)
                        OP_BR: begin
                            if ((r_ins[11:9] & r_cc) != 3'b000) begin
                                r_pc <= alu_y;
                            end
                        end
                        OP_JMP: r_pc <= r_a;
                        OP_JSR: r_pc <= r_ins[11] ? alu_y : r_a;
                        OP_TRAP: begin
                            r_trap <= 1'b1;
                            r_vec  <= r_ins[7:0];
                            if (key_trap && !r_kready) begin
                                // hold at the trap so the host retries
                                r_pc <= r_pc - 16'd1;
                            end else if (r_ins[7:0] == VEC_HALT) begin
                                r_stopped <= 1'b1;
                            end
                        end
                        OP_RTI, OP_RES: begin
                            r_fault   <= 1'b1;
                            r_stopped <= 1'b1;
                        end
                        default: ;
                    endcase
                end
                S_RD: begin
                    if (r_addr == KBSR_ADDR) begin
                        r_val      <= r_kready ? KBSR_READY : 16'h0000;
                        r_from_mem <= 1'b0;
                        r_kused    <= r_kused | r_kready;
                        r_state    <= r_kready ? S_KBDR : S_DATA;
                    end else begin
                        r_from_mem <= 1'b1;
                        r_state    <= S_DATA;
                    end
                end
                S_KBDR: r_state <= S_DATA;
                S_DATA: begin
                    if (r_ind && opc == OP_LDI) begin
                        r_ind   <= 1'b0;
                        r_addr  <= data_val;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_WR0: begin
                    r_kused <= 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_o_pc      <= r_pc;
                        r_o_cc      <= r_cc;
                        r_o_trap    <= r_trap & r_op;
                        r_o_vec     <= r_op ? r_vec : 8'h00;
                        r_o_r0      <= r_r0;
                        r_o_kused   <= r_kused & r_op;
                        r_o_halted  <= r_stopped;
                        r_o_fault   <= r_fault;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_in_stall    = (r_state != S_IDLE) || (r_start_pc == 16'h0000 && 1'b0);
    assign o_out_valid   = r_out_valid;
    assign o_next_pc     = r_o_pc;
    assign o_cond_code   = r_o_cc;
    assign o_trap_taken  = r_o_trap;
    assign o_trap_vector = r_o_vec;
    assign o_reg0_value  = r_o_r0;
    assign o_key_used    = r_o_kused;
    assign o_halted      = r_o_halted;
    assign o_fault       = r_o_fault;

endmodule
